@@ rtl/lsfe_pkg.sv @@
// ----------------------------------------------------------------------------
// lsfe_pkg
// Shared types and constants of the LED strip frame engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfe_pkg;

    localparam int LEN_W   = 6;
    localparam int LEVEL_W = 7;
    localparam int BYTE_W  = 8;
    localparam int AMP_W   = 8;
    localparam int IDX_IN_W = 5;
    localparam int PHASE_W = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    localparam logic [BYTE_W-1:0]  TOP_BIT       = 8'h80;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 7'h7f;
    localparam logic [LEN_W-1:0]   STRIP_LEN_RST = 6'd32;

    typedef enum logic [2:0] {
        OP_SET     = 3'd0,
        OP_FILL    = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_CHECKER = 3'd3,
        OP_SHOW    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET,
        ST_WALK,
        ST_SHOW_RD,
        ST_SHOW_PIX,
        ST_LATCH
    } state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } pixel_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic clr_cnt;
        logic adv_cnt;
        logic wr_set;
        logic wr_walk;
        logic rd_issue;
        logic out_pix;
        logic out_latch;
        logic phase_adv;
    } lsfe_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] in_op;
        logic [2:0] item_op;
        logic       cnt_last;
        logic       out_free;
    } lsfe_status_t;

endpackage

`default_nettype wire

@@ rtl/lsfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsfe_ctrl
// Operation sequencer: decodes an accepted item and steps the datapath
// through pixel writes, store reads and output loads.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfe_ctrl
    import lsfe_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire lsfe_status_t status,
    output lsfe_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (status.in_op)
                        OP_SET:                        state_next = ST_SET;
                        OP_FILL, OP_CLEAR, OP_CHECKER: state_next = ST_WALK;
                        OP_SHOW:                       state_next = ST_SHOW_RD;
                        default:                       state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SET:     state_next = ST_IDLE;
            ST_WALK: begin
                if (status.cnt_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SHOW_RD: state_next = ST_SHOW_PIX;
            ST_SHOW_PIX: begin
                if (status.out_free && status.cnt_last) begin
                    state_next = ST_LATCH;
                end
            end
            ST_LATCH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
                cmd.clr_cnt   = s_valid;
            end
            ST_SET: begin
                cmd.wr_set = 1'b1;
            end
            ST_WALK: begin
                cmd.wr_walk   = 1'b1;
                cmd.adv_cnt   = ~status.cnt_last;
                cmd.phase_adv = status.cnt_last && (status.item_op == OP_CHECKER);
            end
            ST_SHOW_RD: begin
                cmd.rd_issue = 1'b1;
            end
            ST_SHOW_PIX: begin
                if (status.out_free) begin
                    cmd.out_pix = 1'b1;
                    // prefetch the next pixel while this one goes out
                    cmd.adv_cnt  = ~status.cnt_last;
                    cmd.rd_issue = ~status.cnt_last;
                end
            end
            ST_LATCH: begin
                cmd.out_latch = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/lsfe_datapath.sv @@
// ----------------------------------------------------------------------------
// lsfe_datapath
// Pixel store with per-entry valid bits, item and length registers, pixel
// counter, checker phase and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfe_datapath
    import lsfe_pkg::*;
#(
    parameter int MAX_LEDS = 32
)(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_DATA_W-1:0]  s_data,
    input  wire logic                 cfg_we,
    input  wire logic [LEN_W-1:0]     cfg_wdata,
    input  wire lsfe_cmd_t            cmd,
    output lsfe_status_t              status,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output logic [M_DATA_W-1:0]       m_data,
    output logic                      m_latch,
    output logic                      m_last
);

    localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LEDS);

    // input fields
    logic [2:0]          in_op;
    logic [IDX_IN_W-1:0] in_idx;
    logic [LEVEL_W-1:0]  in_red;
    logic [LEVEL_W-1:0]  in_green;
    logic [LEVEL_W-1:0]  in_blue;
    logic [AMP_W-1:0]    in_amp;

    assign in_op    = s_data[2:0];
    assign in_idx   = s_data[7:3];
    assign in_red   = s_data[14:8];
    assign in_green = s_data[21:15];
    assign in_blue  = s_data[28:22];
    assign in_amp   = s_data[36:29];

    logic [LEN_W-1:0]    strip_len_reg;
    logic [LEN_W-1:0]    len_use;
    logic [2:0]          item_op_reg;
    logic [IDX_IN_W-1:0] item_idx_reg;
    pixel_t              item_pix_reg;
    logic [LEVEL_W-1:0]  item_amp_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  walk_ph_reg;
    logic [IDX_W-1:0]    cnt_reg;
    logic [IDX_W-1:0]    cnt_next;

    pixel_t              pix_mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] valid_reg;
    pixel_t              rd_pix_reg;
    logic                rd_valid_reg;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_latch_reg;
    logic                m_last_reg;

    logic [LEN_W-1:0]    set_idx;
    logic                set_ok;
    logic                mem_we;
    logic [IDX_W-1:0]    wr_addr;
    pixel_t              wr_pix;
    pixel_t              walk_pix;
    pixel_t              rd_pix;
    logic                out_free;

    // length in use: zero counts as one, clamp to the store size
    always_comb begin
        if (strip_len_reg == '0) begin
            len_use = LEN_W'(1);
        end else if (strip_len_reg > MAX_LEN) begin
            len_use = MAX_LEN;
        end else begin
            len_use = strip_len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_len_reg <= STRIP_LEN_RST;
        end else if (cfg_we) begin
            strip_len_reg <= cfg_wdata;
        end
    end

    // item capture, amplitude clamped on the way in
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_op_reg        <= in_op;
            item_idx_reg       <= in_idx;
            item_pix_reg.red   <= in_red;
            item_pix_reg.green <= in_green;
            item_pix_reg.blue  <= in_blue;
            item_amp_reg       <= (in_amp > AMP_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                               : in_amp[LEVEL_W-1:0];
        end
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.clr_cnt) begin
            cnt_next = '0;
        end else if (cmd.adv_cnt) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            phase_reg   <= '0;
            walk_ph_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.phase_adv) begin
                phase_reg <= (phase_reg >= PHASE_W'(2)) ? '0 : phase_reg + 1'b1;
            end
            if (cmd.load_item) begin
                walk_ph_reg <= phase_reg;
            end else if (cmd.wr_walk) begin
                walk_ph_reg <= (walk_ph_reg >= PHASE_W'(2)) ? '0 : walk_ph_reg + 1'b1;
            end
        end
    end

    always_comb begin
        walk_pix = '0;
        case (item_op_reg)
            OP_FILL: walk_pix = item_pix_reg;
            OP_CHECKER: begin
                case (walk_ph_reg)
                    2'd0:    walk_pix.red   = item_amp_reg;
                    2'd1:    walk_pix.green = item_amp_reg;
                    default: walk_pix.blue  = item_amp_reg;
                endcase
            end
            default: walk_pix = '0;
        endcase
    end

    // drop a set pixel that falls outside the store
    assign set_idx = LEN_W'(item_idx_reg);
    assign set_ok  = set_idx < MAX_LEN;
    assign mem_we  = cmd.wr_walk || (cmd.wr_set && set_ok);
    assign wr_addr = cmd.wr_set ? set_idx[IDX_W-1:0] : cnt_reg;
    assign wr_pix  = cmd.wr_set ? item_pix_reg : walk_pix;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pix_mem[wr_addr] <= wr_pix;
        end
        if (cmd.rd_issue) begin
            rd_pix_reg   <= pix_mem[cnt_next];
            rd_valid_reg <= valid_reg[cnt_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // an entry never written since reset reads as dark
    assign rd_pix   = rd_valid_reg ? rd_pix_reg : '0;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_pix || cmd.out_latch) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_pix) begin
            m_data_reg  <= {TOP_BIT | BYTE_W'(rd_pix.blue),
                            TOP_BIT | BYTE_W'(rd_pix.red),
                            TOP_BIT | BYTE_W'(rd_pix.green)};
            m_latch_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else if (cmd.out_latch) begin
            // the length never exceeds 63, so one latch group ends every frame
            m_data_reg  <= '0;
            m_latch_reg <= 1'b1;
            m_last_reg  <= 1'b1;
        end
    end

    assign status.in_op    = in_op;
    assign status.item_op  = item_op_reg;
    assign status.cnt_last = (LEN_W'(cnt_reg) == (len_use - 1'b1));
    assign status.out_free = out_free;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign m_latch = m_latch_reg;
    assign m_last  = m_last_reg;

endmodule

`default_nettype wire

@@ rtl/led_strip_frame_engine.sv @@
// ----------------------------------------------------------------------------
// led_strip_frame_engine
// Pixel store for an RGB LED strip with set, fill, clear, checker and show
// operations; show streams G/R/B wire bytes followed by a latch group.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  s_      | in        | s_tvalid/s_tready  | s_tdata: op word, 40 bits
//  m_      | out       | m_tvalid/m_tready  | m_tdata G,R,B; tuser; tlast
//  cfg_    | in        | cfg_we             | cfg_wdata: strip_length
//
//  Set pixel writes at most one store entry; fill, clear and checker walk the strip, one
//  store write per cycle. Show does one store read per pixel through the
//  registered read port, then the latch group.
//  Output stalls hold the show sequence; the output register lets the next
//  item be accepted while the last result still waits.
//  Reset clears the store through per-pixel valid bits, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_frame_engine
    import lsfe_pkg::*;
#(
    parameter int MAX_LEDS = 32
)(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // op[2:0], pixel_index[7:3], red_level[14:8], green_level[21:15],
    // blue_level[28:22], amplitude[36:29], zero pad[39:37]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // green_byte[7:0], red_byte[15:8], blue_byte[23:16]
    output logic [M_DATA_W-1:0]      m_tdata,
    // is_latch[0]
    output logic                     m_tuser,
    output logic                     m_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire logic                cfg_we,
    input  wire logic [LEN_W-1:0]    cfg_wdata
);

    lsfe_cmd_t    cmd;
    lsfe_status_t status;

    lsfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    lsfe_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_ready   (m_tready),
        .m_valid   (m_tvalid),
        .m_data    (m_tdata),
        .m_latch   (m_tuser),
        .m_last    (m_tlast)
    );

    // a show keeps the input closed until its latch group is loaded into the output register
    a_show_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[2:0] == OP_SHOW)) |=> !s_tready)
        else $error("input accepted right after a show transfer");

    a_latch_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("latch group not marked last");

    a_last_is_latch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser && (m_tdata == '0)))
        else $error("frame end without a zero latch group");

    a_pixel_top_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[7] && m_tdata[15] && m_tdata[23]))
        else $error("pixel transfer with a clear top bit");

endmodule

`default_nettype wire
